// ===== sv/mwos_pkg.sv =====
package mwos_pkg;

	localparam logic [1:0] REQ_EVAL = 2'd0;
	localparam logic [1:0] REQ_SAW  = 2'd1;
	localparam logic [1:0] REQ_TRI  = 2'd2;

	localparam logic [1:0] WAVE_SINE   = 2'd0;
	localparam logic [1:0] WAVE_SAW    = 2'd1;
	localparam logic [1:0] WAVE_SQUARE = 2'd2;
	localparam logic [1:0] WAVE_TRI    = 2'd3;

	localparam int unsigned PHASE_W  = 16;
	localparam int unsigned WORD_W   = 16;
	localparam int unsigned SAMPLE_W = 18;
	localparam int unsigned INDEX_W  = 10;
	localparam int unsigned FRAC_W   = 15;
	localparam int unsigned POS_FRAC_W = 16;

	// 0.225 in q15
	localparam logic signed [13:0] SINE_K = 14'sd7373;

	// arithmetic shift right by s, rounded half away from zero
	function automatic logic signed [47:0] rnd_shr(input logic signed [47:0] v,
			input int unsigned s);
		logic [47:0] half;
		logic [47:0] m;
		half = 48'(1) << (s - 1);
		m = v[47] ? 48'(-v) : 48'(v);
		m = (m + half) >> s;
		return v[47] ? -$signed(m) : $signed(m);
	endfunction

endpackage

// ===== sv/multi_wave_oscillator_shaper_unit.sv =====
// multi-wave oscillator shaper
// request channel: in_valid / in_stall with req_type, wave_select, phase,
// entry_index, entry_value. an evaluate request gives one sample of sine,
// saw, square or triangle at the phase; saw and triangle load requests write
// one table word. every request answers exactly one sample (zero for loads)
// on the result channel out_valid / out_stall, in request order.
// the block is a six-stage pipeline; a request accepted into stage 1 moves
// stage by stage to the output register, stage 6, when nothing stalls.
// one request can be accepted every cycle while in_stall is low; the rate is
// set by the table memories, which give two reads and one write per cycle (the
// saw table is kept in two copies so square gets its four reads in the same cycle).
// in_stall is high only when every stage holds a request and the receiver
// stalls the output register; bubbles are squeezed out while stalled.
// a stalled result holds its value. reset clears the stage valid bits only;
// the tables are not cleared, and a table word must be loaded before an
// evaluate request reads it. table size is the TABLE_SIZE parameter, and
// loads with entry_index not below it are dropped but still answered.
module multi_wave_oscillator_shaper_unit #(
	parameter int unsigned TABLE_SIZE = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          req_type,
	input  logic [1:0]          wave_select,
	input  logic signed [15:0]  phase,
	input  logic [9:0]          entry_index,
	input  logic signed [15:0]  entry_value,
	output logic                out_valid,
	input  logic                out_stall,
	output logic signed [17:0]  sample
);
	import mwos_pkg::*;

	localparam int unsigned AW = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
	localparam int unsigned TW = $clog2(TABLE_SIZE + 1);
	localparam int unsigned PW = POS_FRAC_W + TW;
	localparam int unsigned CW = (INDEX_W > TW) ? INDEX_W + 1 : TW + 1;

	// stage valid bits and advance enables
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic en1, en2, en3, en4, en5, en6;

	assign en6 = !v_s6 || !out_stall;
	assign en5 = !v_s5 || en6;
	assign en4 = !v_s4 || en5;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign in_stall = !en1;
	assign out_valid = v_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
			if (en6) v_s6 <= v_s5;
		end
	end

	// stage 1: table positions and u*|u|
	logic [PHASE_W-1:0]        off_p, off_q;
	logic [PW-1:0]             pos_p, pos_q;
	logic signed [PHASE_W:0]   u_mag;
	logic signed [32:0]        uu;
	logic                      idx_ok;

	assign off_p = phase ^ 16'h8000;
	assign off_q = phase;
	assign pos_p = PW'(off_p) * PW'(TABLE_SIZE);
	assign pos_q = PW'(off_q) * PW'(TABLE_SIZE);
	assign u_mag = phase[15] ? -17'(phase) : 17'(phase);
	assign uu = 33'(phase) * 33'(u_mag);
	assign idx_ok = CW'(entry_index) < CW'(TABLE_SIZE);

	logic [1:0]               req_s1, wave_s1;
	logic signed [15:0]       u_s1, val_s1;
	logic [AW-1:0]            lo_p_s1, lo_q_s1, wa_s1;
	logic [15:0]              frac_p_s1, frac_q_s1;
	logic signed [32:0]       uu_s1;
	logic                     idx_ok_s1;

	always_ff @(posedge clk) begin
		if (en1) begin
			req_s1    <= req_type;
			wave_s1   <= wave_select;
			u_s1      <= phase;
			val_s1    <= entry_value;
			wa_s1     <= AW'(entry_index);
			idx_ok_s1 <= idx_ok;
			lo_p_s1   <= pos_p[POS_FRAC_W +: AW];
			lo_q_s1   <= pos_q[POS_FRAC_W +: AW];
			frac_p_s1 <= pos_p[15:0];
			frac_q_s1 <= pos_q[15:0];
			uu_s1     <= uu;
		end
	end

	// stage 2: table reads and writes, parabola
	logic [AW-1:0]            hi_p, hi_q;
	logic                     saw_wr, tri_wr;
	logic signed [47:0]       uu_r;
	logic signed [18:0]       y_w;

	assign hi_p = (lo_p_s1 == AW'(TABLE_SIZE - 1)) ? '0 : lo_p_s1 + AW'(1);
	assign hi_q = (lo_q_s1 == AW'(TABLE_SIZE - 1)) ? '0 : lo_q_s1 + AW'(1);
	assign saw_wr = v_s1 && (req_s1 == REQ_SAW) && idx_ok_s1;
	assign tri_wr = v_s1 && (req_s1 == REQ_TRI) && idx_ok_s1;
	assign uu_r = rnd_shr(48'(uu_s1), FRAC_W);
	assign y_w = (19'(u_s1) <<< 2) - (19'($signed(uu_r[17:0])) <<< 2);

	logic signed [15:0] saw_a_mem [TABLE_SIZE];
	logic signed [15:0] saw_b_mem [TABLE_SIZE];
	logic signed [15:0] tri_mem   [TABLE_SIZE];

	logic signed [15:0]       sa_lo_s2, sa_hi_s2, sb_lo_s2, sb_hi_s2, t_lo_s2, t_hi_s2;
	logic [1:0]               req_s2, wave_s2;
	logic [15:0]              frac_p_s2, frac_q_s2;
	logic signed [17:0]       y_s2;

	always_ff @(posedge clk) begin
		if (en2) begin
			if (saw_wr) begin
				saw_a_mem[wa_s1] <= val_s1;
				saw_b_mem[wa_s1] <= val_s1;
			end
			if (tri_wr) tri_mem[wa_s1] <= val_s1;
			sa_lo_s2  <= saw_a_mem[lo_p_s1];
			sa_hi_s2  <= saw_a_mem[hi_p];
			sb_lo_s2  <= saw_b_mem[lo_q_s1];
			sb_hi_s2  <= saw_b_mem[hi_q];
			t_lo_s2   <= tri_mem[lo_p_s1];
			t_hi_s2   <= tri_mem[hi_p];
			req_s2    <= req_s1;
			wave_s2   <= wave_s1;
			frac_p_s2 <= frac_p_s1;
			frac_q_s2 <= frac_q_s1;
			y_s2      <= y_w[17:0];
		end
	end

	// stage 3: interpolation products, y*|y|
	logic signed [15:0]       a_p, b_p;
	logic signed [16:0]       diff_p, diff_q;
	logic signed [33:0]       prod_p, prod_q;
	logic signed [17:0]       y_mag;
	logic signed [35:0]       yy;

	assign a_p = (wave_s2 == WAVE_TRI) ? t_lo_s2 : sa_lo_s2;
	assign b_p = (wave_s2 == WAVE_TRI) ? t_hi_s2 : sa_hi_s2;
	assign diff_p = 17'(b_p) - 17'(a_p);
	assign diff_q = 17'(sb_hi_s2) - 17'(sb_lo_s2);
	assign prod_p = 34'($signed({1'b0, frac_p_s2})) * 34'(diff_p);
	assign prod_q = 34'($signed({1'b0, frac_q_s2})) * 34'(diff_q);
	assign y_mag = y_s2[17] ? -y_s2 : y_s2;
	assign yy = 36'(y_s2) * 36'(y_mag);

	logic signed [15:0]       a_p_s3, a_q_s3;
	logic signed [33:0]       prod_p_s3, prod_q_s3;
	logic signed [35:0]       yy_s3;
	logic signed [17:0]       y_s3;
	logic [1:0]               req_s3, wave_s3;

	always_ff @(posedge clk) begin
		if (en3) begin
			a_p_s3    <= a_p;
			a_q_s3    <= sb_lo_s2;
			prod_p_s3 <= prod_p;
			prod_q_s3 <= prod_q;
			yy_s3     <= yy;
			y_s3      <= y_s2;
			req_s3    <= req_s2;
			wave_s3   <= wave_s2;
		end
	end

	// stage 4: interpolated values, sine correction term
	logic signed [47:0]       rp, rq, ryy;
	logic signed [17:0]       ip, iq;
	logic signed [18:0]       d_w;

	assign rp = rnd_shr(48'(prod_p_s3), POS_FRAC_W);
	assign rq = rnd_shr(48'(prod_q_s3), POS_FRAC_W);
	assign ryy = rnd_shr(48'(yy_s3), FRAC_W);
	assign ip = 18'(a_p_s3) + $signed(rp[17:0]);
	assign iq = 18'(a_q_s3) + $signed(rq[17:0]);
	assign d_w = 19'($signed(ryy[17:0])) - 19'(y_s3);

	logic signed [17:0]       ip_s4, iq_s4, y_s4;
	logic signed [18:0]       d_s4;
	logic [1:0]               req_s4, wave_s4;

	always_ff @(posedge clk) begin
		if (en4) begin
			ip_s4   <= ip;
			iq_s4   <= iq;
			d_s4    <= d_w;
			y_s4    <= y_s3;
			req_s4  <= req_s3;
			wave_s4 <= wave_s3;
		end
	end

	// stage 5: square difference, scaled correction
	logic signed [17:0]       tab_w;
	logic signed [32:0]       kd;

	assign tab_w = (wave_s4 == WAVE_SQUARE) ? ip_s4 - iq_s4 : ip_s4;
	assign kd = 33'(d_s4) * 33'(SINE_K);

	logic signed [17:0]       tab_s5, y_s5;
	logic signed [32:0]       kd_s5;
	logic [1:0]               req_s5, wave_s5;

	always_ff @(posedge clk) begin
		if (en5) begin
			tab_s5  <= tab_w;
			kd_s5   <= kd;
			y_s5    <= y_s4;
			req_s5  <= req_s4;
			wave_s5 <= wave_s4;
		end
	end

	// stage 6: output register
	logic signed [47:0]       rkd;
	logic signed [17:0]       sine_w, out_w;
	logic signed [17:0]       sample_s6;

	assign rkd = rnd_shr(48'(kd_s5), FRAC_W);
	assign sine_w = y_s5 + $signed(rkd[17:0]);
	assign out_w = (req_s5 != REQ_EVAL) ? '0 :
		(wave_s5 == WAVE_SINE) ? sine_w : tab_s5;

	always_ff @(posedge clk) begin
		if (en6) sample_s6 <= out_w;
	end

	assign sample = sample_s6;

endmodule

// ===== sv/mwos_checker.sv =====
module mwos_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_stall,
	input logic                out_valid,
	input logic                out_stall,
	input logic signed [17:0]  sample
);

	// a held result keeps its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(sample))
		else $error("result changed while stalled");

	// request side only backs up when the result side is full and stalled
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("request stalled without output backpressure");

	// a free receiver never blocks requests
	a_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_stall |-> !in_stall)
		else $error("request stalled with free receiver");

	// nothing comes out during reset
	a_reset_empty: assert property (@(posedge clk)
		!arst_n |-> !out_valid)
		else $error("result valid in reset");

endmodule

bind multi_wave_oscillator_shaper_unit mwos_checker u_mwos_checker (.*);
